@@ sv/sah_pkg.sv @@
// Shared types, codes and constants of the slot allocator with high-water mark.
package sah_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int SLOTS_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	// Valid bits are kept as rows of this many bits in a small memory
	localparam int ROW_BITS = 32;
	localparam int BIT_W    = $clog2(ROW_BITS);

	// Fixed field widths of the stream words
	localparam int ACT_FW      = 2;
	localparam int SLOT_FW     = 10;
	localparam int DATA_FW     = 32;
	localparam int HW_FW       = 11;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 56;

	typedef enum logic [ACT_FW-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TRIM_RD,
		ST_TRIM
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic issue;    // take the input word, start the row and data reads
		logic commit;   // apply the action of the held word
		logic trim_rd;  // read the highest occupied row
		logic trim_fin; // set the high-water mark from that row
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		action_t act;
	} stat_t;

	// Result word, granted_slot in the lowest bits
	typedef struct packed {
		logic [DATA_FW-1:0] read_data;
		logic               read_valid;
		logic [HW_FW-1:0]   high_water;
		logic               accepted;
		logic [SLOT_FW-1:0] granted_slot;
	} res_t;

endpackage

@@ sv/sah_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/sah_ctrl.sv @@
// Controller state machine of the slot allocator.
module sah_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_free,
	input  sah_pkg::stat_t stat,
	output sah_pkg::cmd_t  cmd,
	output logic           res_load
);

	import sah_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.issue = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// a free reports only after the trim, so it need not wait here
				if (stat.act == ACT_FREE) begin
					cmd.commit = 1'b1;
					state_d    = ST_TRIM_RD;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					res_load   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_TRIM_RD: begin
				cmd.trim_rd = 1'b1;
				state_d     = ST_TRIM;
			end
			ST_TRIM: begin
				if (out_free) begin
					cmd.trim_fin = 1'b1;
					res_load     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ sv/sah_dp.sv @@
// Datapath of the slot allocator: valid rows, data store, searches and high-water count.
module sah_dp #(
	parameter int SLOTS      = sah_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = sah_pkg::DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sah_pkg::cmd_t             cmd,
	input  sah_pkg::action_t          in_action,
	input  logic [sah_pkg::SLOT_FW-1:0] in_slot,
	input  logic [sah_pkg::DATA_FW-1:0] in_data,
	output sah_pkg::stat_t            stat,
	output sah_pkg::res_t             res
);

	import sah_pkg::*;

	localparam int SIDX_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ROWS   = (SLOTS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LIN_W  = ROW_W + BIT_W;

	// Per-row summary flags; a row with no occupied slot reads as all clear
	logic [ROWS-1:0]       row_any_q, row_any_d;
	logic [ROWS-1:0]       row_full_q, row_full_d;
	logic [CNT_W-1:0]      top_q, top_d;

	// Held input word
	action_t               act_q;
	logic [ROW_W-1:0]      row_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [ROW_W-1:0]      hrow_q;
	logic                  hany_q;

	logic [ROW_W-1:0]      free_row, hi_row, slot_row, iss_row;
	logic                  free_any, hi_any, slot_rng;
	logic [ROW_BITS-1:0]   vm_rdata, vm_wdata, word, tword, pad, nw;
	logic                  vm_we, dm_we;
	logic [DATA_WIDTH-1:0] dm_rdata;
	logic [BIT_W-1:0]      low_b, hi_b;
	logic [LIN_W-1:0]      lin;
	logic [CNT_W-1:0]      lin_c;

	assign slot_row = ROW_W'(in_slot >> BIT_W);
	assign slot_rng = (32'(in_slot) < SLOTS);

	// Lowest row with a free slot, highest row with an occupied slot
	always_comb begin
		free_row = '0;
		free_any = 1'b0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				free_row = ROW_W'(r);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		hi_row = '0;
		hi_any = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			if (row_any_q[r]) begin
				hi_row = ROW_W'(r);
				hi_any = 1'b1;
			end
		end
	end

	assign iss_row = (in_action == ACT_ALLOC) ? free_row : slot_row;

	sah_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS),
		.AW    (ROW_W)
	) u_valid_ram (
		.clk   (clk),
		.we    (vm_we),
		.waddr (row_q),
		.wdata (vm_wdata),
		.re    (cmd.issue | cmd.trim_rd),
		.raddr (cmd.trim_rd ? hi_row : iss_row),
		.rdata (vm_rdata)
	);

	sah_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (SLOTS),
		.AW    (SIDX_W)
	) u_data_ram (
		.clk   (clk),
		.we    (dm_we),
		.waddr (SIDX_W'(lin)),
		.wdata (data_q),
		.re    (cmd.issue),
		.raddr (SIDX_W'(in_slot)),
		.rdata (dm_rdata)
	);

	// Bits of the last row that lie beyond the table count as taken
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			pad[b] = (32'({row_q, BIT_W'(b)}) >= SLOTS);
		end
	end

	assign word  = vm_rdata & {ROW_BITS{row_any_q[row_q]}};
	assign tword = vm_rdata & {ROW_BITS{hany_q}};

	always_comb begin
		low_b = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (!(word[b] | pad[b])) begin
				low_b = BIT_W'(b);
			end
		end
	end

	always_comb begin
		hi_b = '0;
		for (int b = 0; b < ROW_BITS; b++) begin
			if (tword[b]) begin
				hi_b = BIT_W'(b);
			end
		end
	end

	assign lin   = {row_q, low_b};
	assign lin_c = CNT_W'(lin);

	always_comb begin
		nw        = word;
		vm_we     = 1'b0;
		dm_we     = 1'b0;
		top_d     = top_q;
		row_any_d = row_any_q;
		row_full_d = row_full_q;
		res       = '0;
		if (cmd.commit) begin
			unique case (act_q)
				ACT_ALLOC: begin
					if (ok_q) begin
						nw                = word | (ROW_BITS'(1) << low_b);
						vm_we             = 1'b1;
						dm_we             = 1'b1;
						row_any_d[row_q]  = 1'b1;
						row_full_d[row_q] = &(nw | pad);
						if (lin_c >= top_q) begin
							top_d = lin_c + CNT_W'(1);
						end
						res.granted_slot = SLOT_FW'(lin);
						res.accepted     = 1'b1;
					end
				end
				ACT_FREE: begin
					if (ok_q) begin
						nw                = word & ~(ROW_BITS'(1) << bit_q);
						vm_we             = 1'b1;
						row_any_d[row_q]  = |nw;
						row_full_d[row_q] = 1'b0;
					end
				end
				ACT_READ: begin
					if (ok_q) begin
						res.read_valid = word[bit_q];
						res.read_data  = DATA_FW'(dm_rdata);
					end
				end
				ACT_NOP: begin
				end
			endcase
		end
		// Everything above the highest occupied slot is free
		if (cmd.trim_fin) begin
			top_d = hany_q ? (CNT_W'({hrow_q, hi_b}) + CNT_W'(1)) : '0;
		end
		res.high_water = HW_FW'(top_d);
	end

	assign vm_wdata = nw;
	assign stat.act = act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= '0;
			row_any_q  <= '0;
			row_full_q <= '0;
		end else begin
			top_q      <= top_d;
			row_any_q  <= row_any_d;
			row_full_q <= row_full_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			act_q  <= in_action;
			row_q  <= iss_row;
			bit_q  <= in_slot[BIT_W-1:0];
			ok_q   <= (in_action == ACT_ALLOC) ? free_any : slot_rng;
			data_q <= DATA_WIDTH'(in_data);
		end
		if (cmd.trim_rd) begin
			hrow_q <= hi_row;
			hany_q <= hi_any;
		end
	end

	// A full row is always an occupied row
	a_full_in_any: assert property (@(posedge clk) disable iff (!arst_n)
		(row_full_q & ~row_any_q) == '0)
		else $error("row marked full but not occupied");

	// Between items the mark sits at zero exactly when nothing is occupied
	a_top_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> ((top_q == '0) == (row_any_q == '0)))
		else $error("high-water mark disagrees with occupancy");

	// A granted slot leaves its row occupied and the mark above it
	a_grant_row: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && act_q == ACT_ALLOC && ok_q) |=>
		(row_any_q[$past(row_q)] && top_q > $past(lin_c)))
		else $error("allocation not recorded");

endmodule

@@ sv/slot_allocator_high_water.sv @@
// Top level of the first-fit slot allocator with high-water mark.
//
// Usage: one input stream carries requests, one output stream returns one word per
// request. A request allocates the lowest free slot for its data word, frees a slot,
// reads a slot back, or (code three) only reports the mark. The high-water mark
// counts the slots from zero up to the highest occupied one; allocation beyond it
// raises it, and a free lowers it past every empty slot at the top.
// Steps: allocate, read and the spare code take an accept step, which reads the valid
// row and data memories, and an execute step, which applies the action and loads the
// output register. A free takes two more steps after its action, to read the highest
// occupied valid row and trim the mark; the valid-row memory has a single read port.
// The result shows on the output in the cycle after its last step.
// Reset: asynchronous, clears the per-row occupancy flags and the mark at once, so
// the table is empty straight away and needs no clearing pass; stored data words are
// left as they were, and a read of an empty slot returns one with read_valid clear.
// Stall: the output register holds one finished word; the next request is taken while
// it waits, and that request holds in its final step until the register is free.
module slot_allocator_high_water #(
	parameter int SLOTS      = sah_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = sah_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// action [1:0], slot [11:2], entry_data [43:12], zero [47:44]
	input  logic [sah_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// granted_slot [9:0], accepted [10], high_water [21:11], read_valid [22],
	// read_data [54:23], zero [55]
	output logic [sah_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	import sah_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	res_t    res;
	res_t    m_data_q;
	logic    m_valid_q;
	logic    res_load;
	logic    out_free;
	action_t in_action;

	// Output register is free when empty or being drained this cycle
	assign out_free  = !m_valid_q || m_axis_tready;
	assign in_action = action_t'(s_axis_tdata[ACT_FW-1:0]);

	sah_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.res_load (res_load)
	);

	sah_dp #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_action (in_action),
		.in_slot   (s_axis_tdata[ACT_FW +: SLOT_FW]),
		.in_data   (s_axis_tdata[ACT_FW + SLOT_FW +: DATA_FW]),
		.stat      (stat),
		.res       (res)
	);

	// Hold the result word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

endmodule
